/* hdl/qnlerp_pkg.sv */
// Shared types and fixed widths for the quaternion blend-and-normalize pipeline.
package qnlerp_pkg;

    // The squared-norm accumulator saturates at 64 bits, so its root has 32 bits.
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;

    typedef enum logic {
        REQ_BLEND = 1'b0,
        REQ_IDENT = 1'b1
    } t_req;

endpackage

/* hdl/quaternion_nlerp_normalize_core.sv */
// Throughput: one request per cycle while the output is not stalled; a 32-stage
// square-root line and a radix-2 divider line of COMP_WIDTH + 1 stages per component
// set the depth.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (synchronous, active low) clears only the valid bits.
module quaternion_nlerp_normalize_core
    import qnlerp_pkg::*;
#(
    parameter int COMP_WIDTH       = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic signed [COMP_WIDTH-1:0]  i_a_x,
    input  logic signed [COMP_WIDTH-1:0]  i_a_y,
    input  logic signed [COMP_WIDTH-1:0]  i_a_z,
    input  logic signed [COMP_WIDTH-1:0]  i_a_w,
    input  logic signed [COMP_WIDTH-1:0]  i_b_x,
    input  logic signed [COMP_WIDTH-1:0]  i_b_y,
    input  logic signed [COMP_WIDTH-1:0]  i_b_z,
    input  logic signed [COMP_WIDTH-1:0]  i_b_w,
    input  logic [WEIGHT_FRAC_BITS:0]     i_blend_weight,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COMP_WIDTH-1:0]  o_out_x,
    output logic signed [COMP_WIDTH-1:0]  o_out_y,
    output logic signed [COMP_WIDTH-1:0]  o_out_z,
    output logic signed [COMP_WIDTH-1:0]  o_out_w,
    output logic                          o_zero_norm
);

    localparam int W   = COMP_WIDTH;
    localparam int F   = WEIGHT_FRAC_BITS;
    localparam int BW  = W + 1;
    localparam int PW  = W + F + 2;
    localparam int CW  = W + F + 1;
    localparam int MW  = W + F;
    localparam int DPW = W + BW;
    localparam int DSW = DPW + 2;
    localparam int NW  = MW + W - 1;
    localparam int QW  = W + 1;
    localparam int HW  = NW - QW;
    localparam int XW  = (HW > ROOT_W) ? HW : ROOT_W;
    localparam int NL  = 6 + ROOT_W + QW + 1;

    localparam logic [F:0]   ONE_T  = {1'b1, {F{1'b0}}};
    localparam logic [W-1:0] C_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] C_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW:0]  Q_MAX  = {2'b00, 1'b0, {(W-1){1'b1}}};
    localparam logic [QW:0]  Q_UNIT = {2'b00, 1'b1, {(W-1){1'b0}}};

    logic en;

    // Line that carries valid and the pass-through result to the last stage.
    logic              r_v    [NL];
    logic              r_bsel [NL];
    logic [W-1:0]      r_bp   [NL][4];
    logic              n_bsel;
    logic [W-1:0]      n_bp   [4];

    // Front stages.
    logic signed [W-1:0]   r_a   [4];
    logic signed [BW-1:0]  r_b   [4];
    logic [F:0]            r_t;
    logic signed [DPW-1:0] r_pd  [4];
    logic signed [PW-1:0]  r_pa  [4];
    logic signed [PW-1:0]  r_pb  [4];
    logic                  r_neg;
    logic signed [PW-1:0]  r_pa2 [4];
    logic signed [PW-1:0]  r_pb2 [4];
    logic signed [CW-1:0]  r_c3  [4];
    logic signed [CW-1:0]  r_c4  [4];
    logic [SUM_W-1:0]      r_sqv [4];
    logic                  r_sat4;
    logic signed [CW-1:0]  r_c5  [4];
    logic [SUM_W-1:0]      r_sum;
    logic                  r_z5;

    logic signed [W-1:0]   n_a   [4];
    logic signed [BW-1:0]  n_b   [4];
    logic [F:0]            n_t;
    logic signed [DPW-1:0] n_pd  [4];
    logic signed [PW-1:0]  n_pa  [4];
    logic signed [PW-1:0]  n_pb  [4];
    logic                  n_neg;
    logic signed [CW-1:0]  n_c3  [4];
    logic [SUM_W-1:0]      n_sqv [4];
    logic                  n_sat4;
    logic [SUM_W-1:0]      n_sum;

    // Square-root line.
    logic [ROOT_W+1:0]     r_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0]     r_sq_root [ROOT_W];
    logic [SUM_W-1:0]      r_sq_s    [ROOT_W];
    logic signed [CW-1:0]  r_sq_c    [ROOT_W][4];
    logic                  r_sq_z    [ROOT_W];
    logic [ROOT_W+1:0]     n_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0]     n_sq_root [ROOT_W];
    logic [SUM_W-1:0]      n_sq_s    [ROOT_W];

    // Divider line; entry 0 is the setup stage.
    logic [ROOT_W-1:0]     r_dv_rem [QW+1][4];
    logic [QW-1:0]         r_dv_lo  [QW+1][4];
    logic [QW-1:0]         r_dv_q   [QW+1][4];
    logic                  r_dv_neg [QW+1][4];
    logic                  r_dv_ovf [QW+1][4];
    logic [ROOT_W-1:0]     r_dv_n   [QW+1];
    logic                  r_dv_z   [QW+1];
    logic [ROOT_W-1:0]     n_dv_rem [QW+1][4];
    logic [QW-1:0]         n_dv_lo  [QW+1][4];
    logic [QW-1:0]         n_dv_q   [QW+1][4];
    logic                  n_dv_neg [4];
    logic                  n_dv_ovf [4];

    // Output stage.
    logic                  r_ov;
    logic [W-1:0]          r_out [4];
    logic                  r_zn;
    logic [W-1:0]          n_out [4];
    logic                  n_zn;

    assign en      = !(r_ov && i_stall);
    assign o_stall = !en;

    // Stage 0: target selection, weight clamp and pass-through result.
    always_comb begin
        logic signed [W-1:0] bin [4];
        logic                ident;
        logic                t0;
        logic                t1;
        bin[0] = i_b_x;
        bin[1] = i_b_y;
        bin[2] = i_b_z;
        bin[3] = i_b_w;
        n_a[0] = i_a_x;
        n_a[1] = i_a_y;
        n_a[2] = i_a_z;
        n_a[3] = i_a_w;
        ident  = (t_req'(i_req_type) == REQ_IDENT);
        t0     = (i_blend_weight == '0);
        t1     = (i_blend_weight >= ONE_T);
        n_t    = t1 ? ONE_T : i_blend_weight;
        for (int i = 0; i < 4; i++) begin
            if (ident) begin
                n_b[i] = (i == 3) ? $signed({2'b01, {(W-1){1'b0}}}) : '0;
            end else begin
                n_b[i] = BW'(bin[i]);
            end
            if (t0) begin
                n_bp[i] = n_a[i];
            end else if (ident) begin
                n_bp[i] = (i == 3) ? C_MAX : '0;
            end else begin
                n_bp[i] = bin[i];
            end
        end
        n_bsel = t0 || t1;
    end

    // Stages 1 to 5: products, dot sign, blend, squares and the saturated sum.
    always_comb begin
        logic signed [DSW-1:0] dot;
        logic signed [PW-1:0]  pbs;
        logic signed [CW-1:0]  cabs;
        logic [MW-1:0]         m;
        logic [ROOT_W-1:0]     m32;
        logic [SUM_W+1:0]      acc;
        dot    = '0;
        acc    = '0;
        n_sat4 = 1'b0;
        for (int i = 0; i < 4; i++) begin
            n_pd[i] = DPW'(r_a[i] * r_b[i]);
            n_pa[i] = PW'(r_a[i] * $signed({1'b0, ONE_T - r_t}));
            n_pb[i] = PW'(r_b[i] * $signed({1'b0, r_t}));
            dot     = dot + DSW'(r_pd[i]);
            pbs     = r_neg ? -r_pb2[i] : r_pb2[i];
            n_c3[i] = CW'(r_pa2[i] + pbs);
            cabs    = (r_c3[i] < 0) ? -r_c3[i] : r_c3[i];
            m       = cabs[MW-1:0];
            m32     = ROOT_W'(m);
            if ((MW > ROOT_W) && ((m >> ROOT_W) != '0)) begin
                n_sat4 = 1'b1;
            end
            n_sqv[i] = SUM_W'(m32) * SUM_W'(m32);
            acc      = acc + (SUM_W+2)'(r_sqv[i]);
        end
        n_neg = (dot < 0);
        n_sum = (r_sat4 || (acc[SUM_W+1:SUM_W] != '0)) ? '1 : acc[SUM_W-1:0];
    end

    // Square-root line: one result bit per stage.
    always_comb begin
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  s;
        logic [ROOT_W+3:0] rem2;
        logic [ROOT_W+3:0] trial;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rem  = '0;
                root = '0;
                s    = r_sum;
            end else begin
                rem  = r_sq_rem[k-1];
                root = r_sq_root[k-1];
                s    = r_sq_s[k-1];
            end
            rem2  = {rem, s[SUM_W-1:SUM_W-2]};
            trial = {2'b00, root, 2'b01};
            if (rem2 >= trial) begin
                n_sq_rem[k]  = (ROOT_W+2)'(rem2 - trial);
                n_sq_root[k] = {root[ROOT_W-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = rem2[ROOT_W+1:0];
                n_sq_root[k] = {root[ROOT_W-2:0], 1'b0};
            end
            n_sq_s[k] = s << 2;
        end
    end

    // Divider setup and steps: one quotient bit per stage for each component.
    always_comb begin
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] cabs;
        logic [NW-1:0]        num;
        logic [HW-1:0]        hi;
        logic [ROOT_W-1:0]    dn;
        logic [ROOT_W:0]      rem2;
        for (int i = 0; i < 4; i++) begin
            c    = r_sq_c[ROOT_W-1][i];
            cabs = (c < 0) ? -c : c;
            num  = {cabs[MW-1:0], {(W-1){1'b0}}};
            hi   = num[NW-1:QW];
            dn   = r_sq_root[ROOT_W-1];
            n_dv_neg[i]    = (c < 0);
            n_dv_ovf[i]    = (XW'(hi) >= XW'(dn));
            n_dv_rem[0][i] = n_dv_ovf[i] ? '0 : ROOT_W'(hi);
            n_dv_lo[0][i]  = num[QW-1:0];
            n_dv_q[0][i]   = '0;
        end
        for (int j = 1; j <= QW; j++) begin
            for (int i = 0; i < 4; i++) begin
                rem2 = {r_dv_rem[j-1][i], r_dv_lo[j-1][i][QW-1]};
                if (rem2 >= {1'b0, r_dv_n[j-1]}) begin
                    n_dv_rem[j][i] = ROOT_W'(rem2 - {1'b0, r_dv_n[j-1]});
                    n_dv_q[j][i]   = {r_dv_q[j-1][i][QW-2:0], 1'b1};
                end else begin
                    n_dv_rem[j][i] = rem2[ROOT_W-1:0];
                    n_dv_q[j][i]   = {r_dv_q[j-1][i][QW-2:0], 1'b0};
                end
                n_dv_lo[j][i] = r_dv_lo[j-1][i] << 1;
            end
        end
    end

    // Output stage: round half away from zero, saturate, pick the result.
    always_comb begin
        logic [QW:0] qr;
        logic [QW:0] nq;
        logic        rnd;
        for (int i = 0; i < 4; i++) begin
            rnd = ({1'b0, r_dv_rem[QW][i], 1'b0} >= {2'b00, r_dv_n[QW]});
            qr  = {1'b0, r_dv_q[QW][i]} + {{QW{1'b0}}, rnd};
            nq  = -qr;
            if (!r_dv_neg[QW][i]) begin
                n_out[i] = (r_dv_ovf[QW][i] || (qr > Q_MAX)) ? C_MAX : qr[W-1:0];
            end else begin
                n_out[i] = (r_dv_ovf[QW][i] || (qr > Q_UNIT)) ? C_MIN : nq[W-1:0];
            end
        end
        n_zn = 1'b0;
        if (r_bsel[NL-1]) begin
            for (int i = 0; i < 4; i++) begin
                n_out[i] = r_bp[NL-1][i];
            end
        end else if (r_dv_z[QW]) begin
            n_out[0] = '0;
            n_out[1] = '0;
            n_out[2] = C_MAX;
            n_out[3] = '0;
            n_zn     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NL; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NL; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ov <= r_v[NL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bsel[0] <= n_bsel;
            r_bp[0]   <= n_bp;
            for (int k = 1; k < NL; k++) begin
                r_bsel[k] <= r_bsel[k-1];
                r_bp[k]   <= r_bp[k-1];
            end
            r_a    <= n_a;
            r_b    <= n_b;
            r_t    <= n_t;
            r_pd   <= n_pd;
            r_pa   <= n_pa;
            r_pb   <= n_pb;
            r_neg  <= n_neg;
            r_pa2  <= r_pa;
            r_pb2  <= r_pb;
            r_c3   <= n_c3;
            r_c4   <= r_c3;
            r_sqv  <= n_sqv;
            r_sat4 <= n_sat4;
            r_c5   <= r_c4;
            r_sum  <= n_sum;
            r_z5   <= (n_sum == '0);
            for (int k = 0; k < ROOT_W; k++) begin
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_s[k]    <= n_sq_s[k];
            end
            r_sq_c[0] <= r_c5;
            r_sq_z[0] <= r_z5;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sq_c[k] <= r_sq_c[k-1];
                r_sq_z[k] <= r_sq_z[k-1];
            end
            for (int j = 0; j <= QW; j++) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_lo[j]  <= n_dv_lo[j];
                r_dv_q[j]   <= n_dv_q[j];
            end
            r_dv_neg[0] <= n_dv_neg;
            r_dv_ovf[0] <= n_dv_ovf;
            r_dv_n[0]   <= r_sq_root[ROOT_W-1];
            r_dv_z[0]   <= r_sq_z[ROOT_W-1];
            for (int j = 1; j <= QW; j++) begin
                r_dv_neg[j] <= r_dv_neg[j-1];
                r_dv_ovf[j] <= r_dv_ovf[j-1];
                r_dv_n[j]   <= r_dv_n[j-1];
                r_dv_z[j]   <= r_dv_z[j-1];
            end
            r_out <= n_out;
            r_zn  <= n_zn;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_out_w     = r_out[3];
    assign o_zero_norm = r_zn;

endmodule
